// ----- rtl/core/mmcs_pkg.sv -----
// Shared types and constants of the min/max contrast stretch block.
package mmcs_pkg;

  localparam int unsigned NUM_CHANNELS = 3;
  localparam int unsigned CH_IDX_W     = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int unsigned SAMPLE_W     = 8;
  localparam int unsigned QUEUE_DEPTH  = 4;
  localparam int unsigned QPTR_W       = $clog2(QUEUE_DEPTH);

  localparam logic [2:0]          CH_LIMIT = 3'(NUM_CHANNELS);
  localparam logic [SAMPLE_W-1:0] PIX_MAX  = 8'd255;
  localparam logic [SAMPLE_W-1:0] PIX_MIN  = 8'd0;

  typedef enum logic [1:0] {
    KIND_CLEAR   = 2'd0,
    KIND_MEASURE = 2'd1,
    KIND_ENHANCE = 2'd2
  } kind_e;

  // One classified word on its way from the front end to the back end.
  typedef struct packed {
    kind_e                kind;
    logic [CH_IDX_W-1:0]  ch;
    logic [SAMPLE_W-1:0]  sample;
  } op_t;

  typedef struct packed {
    logic valid;
    op_t  op;
  } push_t;

endpackage

// ----- rtl/core/min_max_contrast_stretch.sv -----
// Top level of the per-channel min/max contrast stretch block.
//
// Each input word carries a kind in tuser (clear, measure, enhance) and a channel
// and 8-bit sample in tdata. Clear resets that channel's min to 255 and max to 0,
// measure folds the sample into the channel's running min and max, and enhance
// returns gain*(sample-min) saturated to 0..255 with gain = floor(255/(max-min))
// taken from a constant lookup. When max is not above min the sample passes
// through unchanged and tuser of the result is set. Words of the unused kind or
// with a channel beyond the configured count are dropped without a result. The
// block takes one word per cycle while its queue has room: the queue pops at most
// one word per cycle and the back end's lookup and 8x8 multiply are each one
// registered stage. An enhance word is written into the queue when accepted,
// then its channel statistics are read and its gain looked up into a register,
// then the multiply and saturate go into the output register. The four-entry
// queue lets the input keep flowing while the output is stalled; tready drops
// only when the queue is full.
module min_max_contrast_stretch (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [1:0] channel, [9:2] sample, [15:10] zero
  input  logic [1:0]  s_axis_tuser,   // [1:0] kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] stretched
  output logic        m_axis_tuser    // [0] flat_range
);
  import mmcs_pkg::*;

  push_t push;
  logic  q_full;
  logic  head_valid;
  op_t   head;
  logic  pop;

  // Classify and drop words of unused kinds or channels.
  mmcs_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .q_full_i      (q_full),
    .push_o        (push)
  );

  // Decouple input acceptance from output stalls.
  mmcs_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .full_o       (q_full),
    .head_valid_o (head_valid),
    .head_o       (head),
    .pop_i        (pop)
  );

  // Hold statistics and compute stretched values in order.
  mmcs_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_valid_i  (head_valid),
    .head_i        (head),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

// ----- rtl/core/mmcs_front.sv -----
// Front end: accept input words, drop unused kinds and channels, hand the rest on.
module mmcs_front (
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  input  logic [15:0]              s_axis_tdata,
  input  logic [1:0]               s_axis_tuser,
  input  logic                     q_full_i,
  output mmcs_pkg::push_t          push_o
);
  import mmcs_pkg::*;

  logic [1:0]          channel;
  logic [SAMPLE_W-1:0] sample;
  logic                kind_ok;
  logic                ch_ok;

  assign channel = s_axis_tdata[1:0];
  assign sample  = s_axis_tdata[9:2];

  always_comb begin
    case (s_axis_tuser)
      KIND_CLEAR, KIND_MEASURE, KIND_ENHANCE: kind_ok = 1'b1;
      default:                                kind_ok = 1'b0;
    endcase
  end

  assign ch_ok         = ({1'b0, channel} < CH_LIMIT);
  assign s_axis_tready = !q_full_i;

  always_comb begin
    push_o.valid     = s_axis_tvalid && !q_full_i && kind_ok && ch_ok;
    push_o.op.kind   = kind_e'(s_axis_tuser);
    push_o.op.ch     = channel[CH_IDX_W-1:0];
    push_o.op.sample = sample;
  end

endmodule

// ----- rtl/core/mmcs_queue.sv -----
// Short queue of classified words between the front and the back end.
module mmcs_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  mmcs_pkg::push_t  push_i,
  output logic             full_o,
  output logic             head_valid_o,
  output mmcs_pkg::op_t    head_o,
  input  logic             pop_i
);
  import mmcs_pkg::*;

  op_t               mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_q, wptr_d;
  logic [QPTR_W-1:0] rptr_q, rptr_d;
  logic [QPTR_W:0]   count_q, count_d;
  logic              do_push;
  logic              do_pop;

  assign full_o       = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
  assign head_valid_o = (count_q != '0);
  assign head_o       = mem_q[rptr_q];
  assign do_push      = push_i.valid && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  always_comb begin
    wptr_d  = do_push ? wptr_q + 1'b1 : wptr_q;
    rptr_d  = do_pop ? rptr_q + 1'b1 : rptr_q;
    count_d = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= push_i.op;
    end
  end

endmodule

// ----- rtl/core/mmcs_back.sv -----
// Back end: channel statistics, gain lookup, multiply and saturate, output register.
module mmcs_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                head_valid_i,
  input  mmcs_pkg::op_t       head_i,
  output logic                pop_o,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [7:0]          m_axis_tdata,
  output logic                m_axis_tuser
);
  import mmcs_pkg::*;

  // floor(255/d) for d in 1..255; zero d is a flat range whose product goes unused.
  function automatic logic [SAMPLE_W-1:0] gain_of(input logic [SAMPLE_W-1:0] d);
    logic [SAMPLE_W-1:0] g;
    if      (d >= 8'd128) g = 8'd1;
    else if (d >= 8'd86)  g = 8'd2;
    else if (d >= 8'd64)  g = 8'd3;
    else if (d >= 8'd52)  g = 8'd4;
    else if (d >= 8'd43)  g = 8'd5;
    else if (d >= 8'd37)  g = 8'd6;
    else if (d >= 8'd32)  g = 8'd7;
    else if (d >= 8'd29)  g = 8'd8;
    else if (d >= 8'd26)  g = 8'd9;
    else if (d >= 8'd24)  g = 8'd10;
    else if (d >= 8'd22)  g = 8'd11;
    else if (d >= 8'd20)  g = 8'd12;
    else if (d >= 8'd19)  g = 8'd13;
    else if (d >= 8'd18)  g = 8'd14;
    else if (d >= 8'd16)  g = 8'd15;
    else if (d >= 8'd15)  g = 8'd17;
    else if (d >= 8'd14)  g = 8'd18;
    else if (d >= 8'd13)  g = 8'd19;
    else if (d >= 8'd12)  g = 8'd21;
    else if (d >= 8'd11)  g = 8'd23;
    else if (d >= 8'd10)  g = 8'd25;
    else if (d >= 8'd9)   g = 8'd28;
    else if (d >= 8'd8)   g = 8'd31;
    else if (d >= 8'd7)   g = 8'd36;
    else if (d >= 8'd6)   g = 8'd42;
    else if (d >= 8'd5)   g = 8'd51;
    else if (d >= 8'd4)   g = 8'd63;
    else if (d >= 8'd3)   g = 8'd85;
    else if (d >= 8'd2)   g = 8'd127;
    else                  g = 8'd255;
    return g;
  endfunction

  logic [SAMPLE_W-1:0] min_q [NUM_CHANNELS];
  logic [SAMPLE_W-1:0] max_q [NUM_CHANNELS];

  logic                s1_valid_q, s1_valid_d;
  logic                s1_flat_q;
  logic [SAMPLE_W-1:0] s1_sample_q;
  logic [SAMPLE_W-1:0] s1_gain_q;
  logic [SAMPLE_W-1:0] s1_pdiff_q;

  logic                out_valid_q;
  logic [SAMPLE_W-1:0] out_data_q, out_data_d;
  logic                out_flat_q;

  logic                adv_out;
  logic                s1_free;
  logic                pop;
  logic [SAMPLE_W-1:0] lo, hi;
  logic                flat;
  logic [SAMPLE_W-1:0] pdiff;
  logic [2*SAMPLE_W-1:0] prod;

  assign adv_out = !out_valid_q || m_axis_tready;
  assign s1_free = !s1_valid_q || adv_out;
  assign pop     = head_valid_i && s1_free;
  assign pop_o   = pop;

  // Statistics of the head word's channel; earlier updates are already in.
  assign lo    = min_q[head_i.ch];
  assign hi    = max_q[head_i.ch];
  assign flat  = (hi <= lo);
  assign pdiff = (head_i.sample > lo) ? head_i.sample - lo : PIX_MIN;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (s1_free) begin
      s1_valid_d = pop && (head_i.kind == KIND_ENHANCE);
    end
  end

  // Fold measure and clear words into the statistics as they leave the queue.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int unsigned c = 0; c < NUM_CHANNELS; c++) begin
        min_q[CH_IDX_W'(c)] <= PIX_MAX;
        max_q[CH_IDX_W'(c)] <= PIX_MIN;
      end
    end else if (pop) begin
      case (head_i.kind)
        KIND_CLEAR: begin
          min_q[head_i.ch] <= PIX_MAX;
          max_q[head_i.ch] <= PIX_MIN;
        end
        KIND_MEASURE: begin
          if (head_i.sample < lo) min_q[head_i.ch] <= head_i.sample;
          if (head_i.sample > hi) max_q[head_i.ch] <= head_i.sample;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      if (adv_out) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_free) begin
      s1_flat_q   <= flat;
      s1_sample_q <= head_i.sample;
      s1_gain_q   <= gain_of(hi - lo);
      s1_pdiff_q  <= pdiff;
    end
    if (adv_out) begin
      out_data_q <= out_data_d;
      out_flat_q <= s1_flat_q;
    end
  end

  assign prod = s1_gain_q * s1_pdiff_q;

  always_comb begin
    if (s1_flat_q) begin
      out_data_d = s1_sample_q;
    end else if (prod > {8'd0, PIX_MAX}) begin
      out_data_d = PIX_MAX;
    end else begin
      out_data_d = prod[SAMPLE_W-1:0];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_flat_q;

endmodule

// ----- dv/tb_min_max_contrast_stretch.sv -----
// Testbench for the per-channel min/max contrast stretch block.
`timescale 1ns / 1ps

module tb_min_max_contrast_stretch;
  import mmcs_pkg::*;

  // Kind code with no meaning; the block drops such words.
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  // First channel index beyond the configured count.
  localparam logic [1:0] CH_OUTSIDE  = 2'(NUM_CHANNELS);
  // Cycles with no handshake on either side before the run is declared hung.
  localparam int unsigned HANG_LIMIT = 2000;
  localparam int unsigned RANDOM_WORDS = 650;
  // Past this many counted random words, both sides stop idling.
  localparam int unsigned CALM_AFTER = 500;
  localparam int unsigned MAX_REPORTS = 10;

  typedef struct {
    logic [7:0] stretched;
    logic       flat;
  } stretch_res_t;

  // Tracks the channel statistics and holds the stretched values still due.
  class stretch_scoreboard;
    logic [7:0]   lo_q [NUM_CHANNELS];
    logic [7:0]   hi_q [NUM_CHANNELS];
    stretch_res_t due_q [$];
    int unsigned  failures;

    function new();
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        lo_q[CH_IDX_W'(c)] = PIX_MAX;
        hi_q[CH_IDX_W'(c)] = PIX_MIN;
      end
      failures = 0;
    endfunction

    // Fold one accepted input word into the statistics; queue an enhance word's result.
    function void note_word(logic [1:0] kind, logic [1:0] ch, logic [7:0] sample);
      stretch_res_t res;
      int           gain;
      int           prod;
      if (ch >= CH_OUTSIDE) return;
      case (kind)
        KIND_CLEAR: begin
          lo_q[ch] = PIX_MAX;
          hi_q[ch] = PIX_MIN;
        end
        KIND_MEASURE: begin
          if (sample < lo_q[ch]) lo_q[ch] = sample;
          if (sample > hi_q[ch]) hi_q[ch] = sample;
        end
        KIND_ENHANCE: begin
          if (hi_q[ch] <= lo_q[ch]) begin
            // Flat range: pass the sample through and raise the flag.
            res.stretched = sample;
            res.flat      = 1'b1;
          end else begin
            res.flat = 1'b0;
            if (sample <= lo_q[ch]) begin
              res.stretched = 8'd0;
            end else begin
              gain = 255 / (int'(hi_q[ch]) - int'(lo_q[ch]));
              prod = gain * (int'(sample) - int'(lo_q[ch]));
              res.stretched = (prod > 255) ? 8'd255 : 8'(prod);
            end
          end
          due_q.push_back(res);
        end
        default: ;
      endcase
    endfunction

    function void report(string msg);
      failures++;
      if (failures <= MAX_REPORTS) $display("%0t: %s", $realtime, msg);
    endfunction

    // Compare one accepted output word with the oldest value still due.
    function void check_result(logic [7:0] stretched, logic flat);
      stretch_res_t want;
      if (due_q.size() == 0) begin
        report($sformatf("unexpected output word stretched=%0d flat=%0b", stretched, flat));
        return;
      end
      want = due_q.pop_front();
      if (stretched !== want.stretched || flat !== want.flat)
        report($sformatf("mismatch: expected stretched=%0d flat=%0b, got stretched=%0d flat=%0b",
                         want.stretched, want.flat, stretched, flat));
    endfunction

    function int unsigned outstanding();
      return due_q.size();
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;   // [1:0] channel, [9:2] sample, [15:10] zero
  logic [1:0]  s_axis_tuser = '0;   // [1:0] kind
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;        // [7:0] stretched
  logic        m_axis_tuser;        // [0] flat_range

  stretch_scoreboard sb = new();

  bit          src_idle_en = 1'b1;
  bit          snk_idle_en = 1'b1;
  int unsigned counted_words = 0;

  min_max_contrast_stretch dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Sample both handshakes with the values that held before the edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready)
        sb.note_word(s_axis_tuser, s_axis_tdata[1:0], s_axis_tdata[9:2]);
      if (m_axis_tvalid && m_axis_tready)
        sb.check_result(m_axis_tdata, m_axis_tuser);
    end
  end

  // Stall the output side in random bursts while idling is enabled.
  initial begin
    wait (rst_ni);
    m_axis_tready <= 1'b1;
    forever begin
      @(posedge clk_i);
      if (snk_idle_en && $urandom_range(0, 7) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Count cycles without any handshake; end the run if it stalls too long.
  initial begin
    int unsigned quiet;
    quiet = 0;
    wait (rst_ni);
    while (quiet < HANG_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no handshake for %0d cycles", $realtime, HANG_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  // Offer one word and hold it until the block takes it. An optional idle
  // burst goes first; valid stays high between back-to-back words.
  task automatic send_word(logic [1:0] kind, logic [1:0] ch, logic [7:0] sample);
    if (src_idle_en && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {6'b0, sample, ch};
    do @(posedge clk_i); while (!s_axis_tready);
    if (ch < CH_OUTSIDE && kind != KIND_UNUSED) counted_words++;
  endtask

  // Sample near a window, clipped to the pixel range.
  function automatic logic [7:0] near(int base, int span);
    int v;
    v = base + $urandom_range(0, span);
    return (v > 255) ? 8'd255 : 8'(v);
  endfunction

  // Clear a channel (usually), measure a few samples, then enhance some.
  task automatic run_sequence();
    logic [1:0] ch;
    int         base;
    int         span;
    int         n_meas;
    int         n_enh;
    ch     = 2'($urandom_range(0, NUM_CHANNELS - 1));
    base   = $urandom_range(0, 255);
    span   = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 15);
    n_meas = $urandom_range(0, 8);
    n_enh  = $urandom_range(1, 10);
    if ($urandom_range(0, 3) != 0) send_word(KIND_CLEAR, ch, 8'($urandom_range(0, 255)));
    repeat (n_meas) send_word(KIND_MEASURE, ch, near(base, span));
    repeat (n_enh) begin
      if ($urandom_range(0, 2) == 0) send_word(KIND_ENHANCE, ch, 8'($urandom_range(0, 255)));
      else send_word(KIND_ENHANCE, ch, near(base > 4 ? base - 4 : 0, span + 8));
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Flat range straight after reset, at both sample extremes.
    send_word(KIND_ENHANCE, 2'd0, 8'd0);
    send_word(KIND_ENHANCE, 2'd1, 8'd255);
    // One measured sample: max equals min, still flat.
    send_word(KIND_MEASURE, 2'd0, 8'd50);
    send_word(KIND_ENHANCE, 2'd0, 8'd50);
    // Range 50..200: below min, at min, inside, at max, above max.
    send_word(KIND_MEASURE, 2'd0, 8'd200);
    send_word(KIND_ENHANCE, 2'd0, 8'd10);
    send_word(KIND_ENHANCE, 2'd0, 8'd50);
    send_word(KIND_ENHANCE, 2'd0, 8'd51);
    send_word(KIND_ENHANCE, 2'd0, 8'd125);
    send_word(KIND_ENHANCE, 2'd0, 8'd200);
    send_word(KIND_ENHANCE, 2'd0, 8'd255);
    // Full range, gain of one.
    send_word(KIND_MEASURE, 2'd1, 8'd0);
    send_word(KIND_MEASURE, 2'd1, 8'd255);
    send_word(KIND_ENHANCE, 2'd1, 8'd0);
    send_word(KIND_ENHANCE, 2'd1, 8'd128);
    send_word(KIND_ENHANCE, 2'd1, 8'd255);
    // Range of one, largest gain, saturating above max.
    send_word(KIND_MEASURE, 2'd2, 8'd100);
    send_word(KIND_MEASURE, 2'd2, 8'd101);
    send_word(KIND_ENHANCE, 2'd2, 8'd101);
    send_word(KIND_ENHANCE, 2'd2, 8'd102);
    send_word(KIND_ENHANCE, 2'd2, 8'd100);
    // Channel beyond the count and the unused kind: dropped.
    send_word(KIND_MEASURE, CH_OUTSIDE, 8'd0);
    send_word(KIND_ENHANCE, CH_OUTSIDE, 8'd255);
    send_word(KIND_UNUSED, 2'd0, 8'd170);
    // Clear returns the channel to the flat state.
    send_word(KIND_CLEAR, 2'd0, 8'd85);
    send_word(KIND_ENHANCE, 2'd0, 8'd77);

    counted_words = 0;
    while (counted_words < RANDOM_WORDS) begin
      if (counted_words >= CALM_AFTER) begin
        src_idle_en = 1'b0;
        snk_idle_en = 1'b0;
      end
      if ($urandom_range(0, 5) == 0)
        send_word(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                  8'($urandom_range(0, 255)));
      else
        run_sequence();
    end
    s_axis_tvalid <= 1'b0;

    // Drain outstanding results, then idle on so that any stray output word is caught.
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    if (sb.failures == 0 && sb.outstanding() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/mmcs_pkg.sv
rtl/core/mmcs_front.sv
rtl/core/mmcs_queue.sv
rtl/core/mmcs_back.sv
rtl/core/min_max_contrast_stretch.sv
dv/tb_min_max_contrast_stretch.sv
